### src/arpc_pkg.sv
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;   // holds 0..MAX_RESULTS

  // opcodes
  localparam logic [2:0] OP_RESOLVE = 3'd0;
  localparam logic [2:0] OP_REPLY   = 3'd1;
  localparam logic [2:0] OP_REQUEST = 3'd2;
  localparam logic [2:0] OP_TIMEOUT = 3'd3;
  localparam logic [2:0] OP_SERVICE = 3'd4;

  // actions
  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_HIT     = 4'd1;
  localparam logic [3:0] ACT_QUEUED  = 4'd2;
  localparam logic [3:0] ACT_SEND    = 4'd3;
  localparam logic [3:0] ACT_NO_SLOT = 4'd4;
  localparam logic [3:0] ACT_CANCEL  = 4'd5;
  localparam logic [3:0] ACT_REPLY   = 4'd6;
  localparam logic [3:0] ACT_FLUSH   = 4'd7;
  localparam logic [3:0] ACT_FAILED  = 4'd8;
  localparam logic [3:0] ACT_DROPPED = 4'd9;

  // entry states
  localparam logic [2:0] ST_FREE  = 3'd0;
  localparam logic [2:0] ST_SENT  = 3'd1;
  localparam logic [2:0] ST_RETRY = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_VALID = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_MAX_ATT  = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_CLEANUP  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [31:0] target_ip;
    logic [3:0]  entry_index;
    logic [31:0] now_ticks;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  slot;
    logic [31:0] result_ip;
    logic [47:0] result_mac;
    logic        last;
  } rsp_t;

endpackage

### src/arpc_ram.sv
`timescale 1ns / 1ps
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/arp_cache_engine.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// cmd       in   cmd_valid/cmd_stall  cmd_t: opcode, addresses, index, ticks
// rsp       out  rsp_valid/rsp_stall  rsp_t: action, slot, ip, mac, last
// cfg       in   cfg_we               cfg_index selects register, cfg_data
//
// One item at a time. An item scans the table through the entry memories,
// one entry per cycle while the rsp channel does not hold it, with the read
// registered one entry ahead; a claimed slot adds a write step, and a service
// item may add an aging pass. Timeouts, dropped packets and unused opcodes skip the scan.
// Reset (rst, synchronous) frees every entry at once; no clearing pass.
// A stalled rsp channel holds the scan in place; results are never lost.
module arp_cache_engine
  import arpc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (IW > 4) ? IW + 1 : 5;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FIN  = 5'b00100,
    S_AGE  = 5'b01000,
    S_DONE = 5'b10000
  } fsm_t;

  // configuration
  logic [31:0] own_ip, lifetime_ticks, cleanup_interval, last_cleanup;
  logic [3:0]  max_attempts;

  fsm_t state, fsm_next;
  cmd_t cur;
  logic [2:0]    st [ENTRIES];
  logic [CW-1:0] cnt;
  logic [IW-1:0] p, fr, old, tgt;
  logic          p_valid, fr_found, old_found;
  logic [31:0]   min_t;
  logic [CNT_W-1:0] n;

  // result staging: pend holds the newest result until we know if it is last
  rsp_t pend, emit_d, fin_item;
  logic pend_valid, emit_req, hold, can_load;

  // memory ports
  logic [IW-1:0] rd_addr, wa;
  logic [31:0]   d_ip, d_lu;
  logic [47:0]   d_mac;
  logic [3:0]    d_att, att_wd;
  logic ip_we_r, mac_we_r, lu_we_r, att_we_r;
  logic st_we;
  logic [IW-1:0] st_wa;
  logic [2:0]    st_wd;
  logic set_fr, set_old, accept;
  logic [2:0]    s_cur;
  logic [XW-1:0] idx_x;
  logic [IW-1:0] tgt_sel;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign can_load  = !rsp_valid || !rsp_stall;
  assign hold      = emit_req && pend_valid && !can_load;
  assign s_cur     = st[p];
  assign idx_x     = XW'(cmd.entry_index);
  assign rd_addr   = hold ? p : cnt[IW-1:0];
  assign wa        = (state == S_FIN) ? tgt : p;
  assign tgt_sel   = fr_found ? fr : old;

  always_comb begin
    fin_item      = pend;
    fin_item.last = 1'b1;
    if (!pend_valid) begin
      fin_item = '{action: ACT_NONE, slot: 4'd0, result_ip: 32'd0,
                   result_mac: 48'd0, last: 1'b1};
    end
  end

  always_comb begin
    fsm_next = state;
    emit_req = 1'b0;
    emit_d   = '{action: ACT_NONE, slot: 4'(p), result_ip: cur.ip_addr,
                 result_mac: 48'd0, last: 1'b0};
    ip_we_r = 1'b0; mac_we_r = 1'b0; lu_we_r = 1'b0; att_we_r = 1'b0;
    att_wd  = (d_att == 4'hF) ? d_att : d_att + 4'd1;
    st_we = 1'b0; st_wa = p; st_wd = ST_FREE;
    set_fr = 1'b0; set_old = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          fsm_next = S_DONE;
          emit_d.slot      = 4'd0;
          emit_d.result_ip = cmd.ip_addr;
          case (cmd.opcode)
            OP_RESOLVE, OP_SERVICE: fsm_next = S_SCAN;
            OP_REPLY, OP_REQUEST: begin
              if (own_ip == 32'd0 || cmd.target_ip != own_ip) begin
                emit_req = 1'b1;
                emit_d.action = ACT_DROPPED;
              end else begin
                fsm_next = S_SCAN;
                if (cmd.opcode == OP_REQUEST) begin
                  emit_req = 1'b1;
                  emit_d.action     = ACT_REPLY;
                  emit_d.result_mac = cmd.mac_addr;
                end
              end
            end
            OP_TIMEOUT: begin
              if (idx_x < XW'(ENTRIES)) begin
                if (st[idx_x[IW-1:0]] == ST_SENT) begin
                  st_we = 1'b1; st_wa = idx_x[IW-1:0]; st_wd = ST_RETRY;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (p_valid && !(cur.opcode == OP_SERVICE && n == CNT_W'(MAX_RESULTS))) begin
          case (cur.opcode)
            OP_RESOLVE: begin
              if (s_cur == ST_FREE) begin
                set_fr = !fr_found;
              end else if (s_cur inside {ST_SENT, ST_RETRY, ST_FLUSH}) begin
                if (d_ip == cur.ip_addr) begin
                  lu_we_r = 1'b1; emit_req = 1'b1;
                  emit_d.action = ACT_QUEUED; fsm_next = S_DONE;
                end
              end else if (s_cur == ST_VALID) begin
                set_old = !old_found || (d_lu < min_t);
                if (d_ip == cur.ip_addr) begin
                  lu_we_r = 1'b1; emit_req = 1'b1;
                  emit_d.action = ACT_HIT; emit_d.result_mac = d_mac;
                  fsm_next = S_DONE;
                end
              end
            end
            OP_REPLY: begin
              if ((s_cur inside {ST_SENT, ST_RETRY}) && d_ip == cur.ip_addr) begin
                mac_we_r = 1'b1; st_we = 1'b1; st_wd = ST_FLUSH;
                emit_req = 1'b1; emit_d.action = ACT_CANCEL;
                emit_d.result_mac = cur.mac_addr; fsm_next = S_DONE;
              end
            end
            OP_REQUEST: begin
              if (s_cur == ST_FREE) begin
                set_fr = !fr_found;
              end else if (d_ip == cur.ip_addr) begin
                fsm_next = S_DONE;
              end
            end
            default: begin
              emit_d.result_ip = d_ip;
              if (s_cur == ST_RETRY) begin
                att_we_r = 1'b1; st_we = 1'b1; emit_req = 1'b1;
                if (d_att < max_attempts) begin
                  st_wd = ST_SENT; emit_d.action = ACT_SEND;
                end else begin
                  st_wd = ST_FREE; emit_d.action = ACT_FAILED;
                end
              end else if (s_cur == ST_FLUSH) begin
                st_we = 1'b1; st_wd = ST_VALID; emit_req = 1'b1;
                emit_d.action = ACT_FLUSH; emit_d.result_mac = d_mac;
              end
            end
          endcase
        end else if (p_valid || cnt == CW'(ENTRIES)) begin
          // scan finished (or service result limit reached)
          fsm_next = S_DONE;
          case (cur.opcode)
            OP_RESOLVE: begin
              if (fr_found || old_found) begin
                fsm_next = S_FIN;
              end else begin
                emit_req = 1'b1; emit_d.action = ACT_NO_SLOT; emit_d.slot = 4'd0;
              end
            end
            OP_REQUEST: if (fr_found) fsm_next = S_FIN;
            OP_SERVICE: begin
              if (cur.now_ticks - last_cleanup >= cleanup_interval) fsm_next = S_AGE;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        fsm_next = S_DONE;
        st_we = 1'b1; st_wa = tgt;
        ip_we_r = 1'b1; lu_we_r = 1'b1;
        if (cur.opcode == OP_RESOLVE) begin
          st_wd = ST_SENT; att_we_r = 1'b1; att_wd = 4'd1;
          emit_req = 1'b1; emit_d.action = ACT_SEND; emit_d.slot = 4'(tgt);
        end else begin
          st_wd = ST_VALID; mac_we_r = 1'b1;
        end
      end
      S_AGE: begin
        if (p_valid) begin
          if (s_cur == ST_VALID && (cur.now_ticks - d_lu) > lifetime_ticks) begin
            st_we = 1'b1; st_wd = ST_FREE;
          end
        end else if (cnt == CW'(ENTRIES)) begin
          fsm_next = S_DONE;
        end
      end
      S_DONE: if (can_load) fsm_next = S_IDLE;
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      own_ip <= 32'd0; max_attempts <= 4'd3;
      lifetime_ticks <= 32'd60000; cleanup_interval <= 32'd6000;
      last_cleanup <= 32'd0;
      for (int i = 0; i < ENTRIES; i++) st[i] <= ST_FREE;
      rsp_valid <= 1'b0; pend_valid <= 1'b0; p_valid <= 1'b0;
      cnt <= '0; n <= '0; fr_found <= 1'b0; old_found <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OWN_IP:   own_ip <= cfg_data;
          REG_MAX_ATT:  max_attempts <= cfg_data[3:0];
          REG_LIFETIME: lifetime_ticks <= cfg_data;
          REG_CLEANUP:  cleanup_interval <= cfg_data;
          default: ;
        endcase
      end
      // drain the output register
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (!hold) begin
        state <= fsm_next;
        if (st_we) st[st_wa] <= st_wd;
        if (emit_req) begin
          if (pend_valid) begin
            rsp <= pend; rsp_valid <= 1'b1;
          end
          pend <= emit_d; pend_valid <= 1'b1;
          n <= n + CNT_W'(1);
        end
        if (set_fr) begin
          fr <= p; fr_found <= 1'b1;
        end
        if (set_old) begin
          old <= p; old_found <= 1'b1; min_t <= d_lu;
        end
        if (state == S_SCAN && fsm_next == S_FIN) tgt <= tgt_sel;
        if (accept) begin
          cur <= cmd; cnt <= '0; p_valid <= 1'b0; n <= '0;
          fr_found <= 1'b0; old_found <= 1'b0;
        end else if (state == S_SCAN && fsm_next == S_AGE) begin
          last_cleanup <= cur.now_ticks; cnt <= '0; p_valid <= 1'b0;
        end else if (state == S_SCAN || state == S_AGE) begin
          // advance the read pointer one entry ahead of evaluation
          if (cnt < CW'(ENTRIES)) begin
            p <= cnt[IW-1:0]; p_valid <= 1'b1; cnt <= cnt + CW'(1);
          end else begin
            p_valid <= 1'b0;
          end
        end
        if (state == S_DONE && can_load) begin
          rsp <= fin_item; rsp_valid <= 1'b1; pend_valid <= 1'b0;
        end
      end
    end
  end

  arpc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ip (
    .clk(clk), .we(ip_we_r && !hold), .waddr(wa), .wdata(cur.ip_addr),
    .raddr(rd_addr), .rdata(d_ip));
  arpc_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_mac (
    .clk(clk), .we(mac_we_r && !hold), .waddr(wa), .wdata(cur.mac_addr),
    .raddr(rd_addr), .rdata(d_mac));
  arpc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_lu (
    .clk(clk), .we(lu_we_r && !hold), .waddr(wa), .wdata(cur.now_ticks),
    .raddr(rd_addr), .rdata(d_lu));
  arpc_ram #(.WIDTH(4), .DEPTH(ENTRIES)) u_att (
    .clk(clk), .we(att_we_r && !hold), .waddr(wa), .wdata(att_wd),
    .raddr(rd_addr), .rdata(d_att));

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE) else $error("item accepted but engine idle");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("staged result left over");
  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(MAX_RESULTS)) else $error("result count overflow");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && can_load) |=> rsp_valid && rsp.last && state == S_IDLE)
    else $error("final result not flagged last");

endmodule
